[src/lta_pkg.sv]
// ----------------------------------------------------------------------------
// lta_pkg
// shared types and constants for the lock table arbiter
// ----------------------------------------------------------------------------
package lta_pkg;

  // default table geometry
  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned KeyWidthDef     = 16;

  // fixed field widths
  localparam int unsigned OwnerWidth  = 2;
  localparam int unsigned SlotWidth   = 4;
  localparam int unsigned StatusWidth = 3;

  typedef enum logic [StatusWidth-1:0] {
    StGranted  = 3'd0,
    StPending  = 3'd1,
    StReleased = 3'd2,
    StIgnored  = 3'd3,
    StFull     = 3'd4
  } status_e;

  // search unit report to the request sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } srch_stat_t;

endpackage

[src/lta_ram.sv]
// ----------------------------------------------------------------------------
// lta_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lta_ram #(
  parameter int unsigned Width = 18,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/lta_search.sv]
// ----------------------------------------------------------------------------
// lta_search
// linear table search, one entry compared per cycle with a shared comparator
// ----------------------------------------------------------------------------
module lta_search #(
  parameter int unsigned TABLE_ENTRIES = lta_pkg::TableEntriesDef,
  parameter int unsigned KEY_WIDTH     = lta_pkg::KeyWidthDef,
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [KEY_WIDTH-1:0]            key_i,
  input  logic [CntW-1:0]                 count_i,
  output logic [IdxW-1:0]                 rd_addr_o,
  input  logic [KEY_WIDTH-1:0]            rd_key_i,
  input  logic [lta_pkg::OwnerWidth-1:0]  rd_owner_i,
  output lta_pkg::srch_stat_t             stat_o,
  output logic [IdxW-1:0]                 idx_o,
  output logic [lta_pkg::OwnerWidth-1:0]  owner_o
);

  localparam logic SR_IDLE = 1'b0;
  localparam logic SR_CMP  = 1'b1;

  logic                           state_q, state_d;
  logic [IdxW-1:0]                idx_q, idx_d;
  logic                           done_q, done_d;
  logic                           hit_q, hit_d;
  logic [lta_pkg::OwnerWidth-1:0] owner_q, owner_d;
  logic [IdxW-1:0]                idx_inc;
  logic                           last_entry;

  assign idx_inc    = idx_q + IdxW'(1);
  // valid entries always form a prefix of the table
  assign last_entry = (CntW'(idx_q) + CntW'(1)) == count_i;
  assign rd_addr_o  = (state_q == SR_IDLE) ? '0 : idx_inc;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    hit_d   = hit_q;
    owner_d = owner_q;
    unique case (state_q)
      SR_IDLE: begin
        if (start_i) begin
          idx_d = '0;
          hit_d = 1'b0;
          if (count_i == '0) begin
            done_d = 1'b1;
          end else begin
            state_d = SR_CMP;
          end
        end
      end
      SR_CMP: begin
        if (rd_key_i == key_i) begin
          hit_d   = 1'b1;
          done_d  = 1'b1;
          owner_d = rd_owner_i;
          state_d = SR_IDLE;
        end else if (last_entry) begin
          done_d  = 1'b1;
          state_d = SR_IDLE;
        end else begin
          idx_d = idx_inc;
        end
      end
      default: state_d = SR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SR_IDLE;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    owner_q <= owner_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.hit  = hit_q;
  assign idx_o       = idx_q;
  assign owner_o     = owner_q;

endmodule

[src/lock_table_arbiter.sv]
// ----------------------------------------------------------------------------
// lock_table_arbiter
// lock manager for several cores: acquire and release of lock identifiers
// against a bounded table searched one entry per cycle
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | in        | in_valid_i / in_stall_o  | func, requesting_core, lock_key
//  out     | out       | out_valid_o / out_stall_i| status, clear_mailbox, entry_slot
//
//  the result is loaded into the output register after the search, which visits
//  the occupied entries up to a match (0 to TABLE_ENTRIES of them); the next
//  request is taken once the result is loaded
//  the search walks the key/owner ram one entry per cycle through one comparator
//  in_stall_o is high from acceptance until the result is loaded into the
//  output register; a stalled output holds the block in its update stage
//  reset empties the table (fill count and held flags); ram contents are kept
// ----------------------------------------------------------------------------
module lock_table_arbiter #(
  parameter int unsigned TABLE_ENTRIES = lta_pkg::TableEntriesDef,
  parameter int unsigned KEY_WIDTH     = lta_pkg::KeyWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [lta_pkg::OwnerWidth-1:0]  requesting_core_i,
  input  logic [KEY_WIDTH-1:0]            lock_key_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lta_pkg::StatusWidth-1:0] status_o,
  output logic                            clear_mailbox_o,
  output logic [lta_pkg::SlotWidth-1:0]   entry_slot_o
);

  localparam int unsigned IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned OwnW  = lta_pkg::OwnerWidth;
  localparam int unsigned RamW  = KEY_WIDTH + OwnW;

  localparam logic [1:0] T_IDLE   = 2'd0;
  localparam logic [1:0] T_SEARCH = 2'd1;
  localparam logic [1:0] T_DECIDE = 2'd2;

  logic [1:0]               state_q, state_d;
  logic                     func_q;
  logic [OwnW-1:0]          core_q;
  logic [KEY_WIDTH-1:0]     key_q;
  logic [CntW-1:0]          count_q, count_d;
  logic [TABLE_ENTRIES-1:0] held_q, held_d;

  logic                     out_valid_q, out_valid_d;
  lta_pkg::status_e         status_q, status_d;
  logic                     clear_q, clear_d;
  logic [lta_pkg::SlotWidth-1:0] slot_out_q, slot_out_d;

  logic                     in_accept;
  logic                     out_free;
  lta_pkg::srch_stat_t      srch_stat;
  logic [IdxW-1:0]          srch_idx;
  logic [OwnW-1:0]          srch_owner;
  logic [IdxW-1:0]          rd_addr;
  logic [RamW-1:0]          rd_data;
  logic                     ram_we;

  logic                     full;
  logic [IdxW-1:0]          slot;
  logic                     held_cur;

  assign in_stall_o = (state_q != T_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  lta_ram #(
    .Width (RamW),
    .Depth (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i ({key_q, core_q}),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  lta_search #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_WIDTH     (KEY_WIDTH)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .key_i      (key_q),
    .count_i    (count_q),
    .rd_addr_o  (rd_addr),
    .rd_key_i   (rd_data[RamW-1:OwnW]),
    .rd_owner_i (rd_data[OwnW-1:0]),
    .stat_o     (srch_stat),
    .idx_o      (srch_idx),
    .owner_o    (srch_owner)
  );

  // a miss claims the first free slot, which is the fill count
  assign full     = !srch_stat.hit && (count_q == CntW'(TABLE_ENTRIES));
  assign slot     = srch_stat.hit ? srch_idx : count_q[IdxW-1:0];
  assign held_cur = srch_stat.hit && held_q[slot];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    clear_d     = clear_q;
    slot_out_d  = slot_out_q;
    ram_we      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      T_IDLE: begin
        if (in_accept) begin
          state_d = T_SEARCH;
        end
      end
      T_SEARCH: begin
        if (srch_stat.done) begin
          state_d = T_DECIDE;
        end
      end
      T_DECIDE: begin
        if (out_free) begin
          state_d     = T_IDLE;
          out_valid_d = 1'b1;
          clear_d     = 1'b0;
          if (full) begin
            status_d   = lta_pkg::StFull;
            slot_out_d = '0;
          end else begin
            slot_out_d = lta_pkg::SlotWidth'(slot);
            if (!srch_stat.hit) begin
              count_d = count_q + CntW'(1);
              ram_we  = 1'b1;
            end
            if (!func_q) begin
              if (!held_cur) begin
                held_d[slot] = 1'b1;
                ram_we       = 1'b1;
                status_d     = lta_pkg::StGranted;
                clear_d      = 1'b1;
              end else begin
                status_d = lta_pkg::StPending;
              end
            end else begin
              if (held_cur && (srch_owner == core_q)) begin
                held_d[slot] = 1'b0;
                status_d     = lta_pkg::StReleased;
                clear_d      = 1'b1;
              end else begin
                // a claimed entry stays unheld; a hit entry keeps its held flag
                held_d[slot] = held_cur;
                status_d     = lta_pkg::StIgnored;
              end
            end
          end
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      count_q     <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= func_i;
      core_q <= requesting_core_i;
      key_q  <= lock_key_i;
    end
    status_q   <= status_d;
    clear_q    <= clear_d;
    slot_out_q <= slot_out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign clear_mailbox_o = clear_q;
  assign entry_slot_o    = slot_out_q;

  // fill count stays within the table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  // search completion only while the sequencer waits for it
  a_done_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_stat.done |-> (state_q == T_SEARCH))
    else $error("search finished outside search stage");

  // a hit needs at least one occupied entry
  a_hit_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (srch_stat.done && srch_stat.hit) |-> (count_q != '0))
    else $error("search hit on empty table");

  // a full-table result never clears a mailbox and leaves the count alone
  a_full_no_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && (status_q == lta_pkg::StFull))
      |-> (!clear_q && $stable(count_q)))
    else $error("table full result with side effects");

endmodule

[tb/lock_table_checker.sv]
// ----------------------------------------------------------------------------
// lock_table_checker
// watches both channels of the lock table arbiter, keeps its own copy of the
// lock table, works out the outcome of every accepted request and compares
// each result field by field against the oldest outcome still outstanding
// ----------------------------------------------------------------------------
module lock_table_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            func_i,
  input  logic [lta_pkg::OwnerWidth-1:0]  requesting_core_i,
  input  logic [lta_pkg::KeyWidthDef-1:0] lock_key_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [lta_pkg::StatusWidth-1:0] status_i,
  input  logic                            clear_mailbox_i,
  input  logic [lta_pkg::SlotWidth-1:0]   entry_slot_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FnRelease = 1'b1;

  typedef struct packed {
    lta_pkg::status_e              status;
    logic                          clear;
    logic [lta_pkg::SlotWidth-1:0] slot;
  } lock_outcome_t;

  logic                            tbl_valid [lta_pkg::TableEntriesDef];
  logic [lta_pkg::KeyWidthDef-1:0] tbl_key   [lta_pkg::TableEntriesDef];
  logic                            tbl_held  [lta_pkg::TableEntriesDef];
  logic [lta_pkg::OwnerWidth-1:0]  tbl_owner [lta_pkg::TableEntriesDef];

  lock_outcome_t outcome_q [$];

  // looks the key up, claims the lowest free slot on a miss, then applies
  // the acquire or release to the entry
  function automatic lock_outcome_t resolve_request(
    input logic                            is_release,
    input logic [lta_pkg::OwnerWidth-1:0]  core,
    input logic [lta_pkg::KeyWidthDef-1:0] key
  );
    lock_outcome_t res;
    int            hit;
    int            spare;
    hit   = -1;
    spare = -1;
    for (int i = 0; i < lta_pkg::TableEntriesDef; i++) begin
      if (tbl_valid[i]) begin
        if (hit < 0 && tbl_key[i] == key) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (hit < 0 && spare >= 0) begin
      hit            = spare;
      tbl_valid[hit] = 1'b1;
      tbl_key[hit]   = key;
      tbl_held[hit]  = 1'b0;
    end
    res.clear = 1'b0;
    res.slot  = '0;
    if (hit < 0) begin
      res.status = lta_pkg::StFull;
    end else begin
      res.slot = lta_pkg::SlotWidth'(hit);
      if (is_release != FnRelease) begin
        if (!tbl_held[hit]) begin
          tbl_held[hit]  = 1'b1;
          tbl_owner[hit] = core;
          res.status     = lta_pkg::StGranted;
          res.clear      = 1'b1;
        end else begin
          // also covers a second acquire by the current owner
          res.status = lta_pkg::StPending;
        end
      end else if (tbl_held[hit] && tbl_owner[hit] == core) begin
        tbl_held[hit] = 1'b0;
        res.status    = lta_pkg::StReleased;
        res.clear     = 1'b1;
      end else begin
        res.status = lta_pkg::StIgnored;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lock_outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < lta_pkg::TableEntriesDef; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_held[i]  = 1'b0;
      end
      outcome_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding: status %0d slot %0d",
                 status_i, entry_slot_i);
          fail_count_o++;
        end else begin
          want = outcome_q.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (clear_mailbox_i !== want.clear) begin
            $error("clear_mailbox: expected %0d, got %0d", want.clear, clear_mailbox_i);
            fail_count_o++;
          end
          if (entry_slot_i !== want.slot) begin
            $error("entry_slot: expected %0d, got %0d", want.slot, entry_slot_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        outcome_q = {outcome_q, resolve_request(func_i, requesting_core_i, lock_key_i)};
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

[tb/lock_table_arbiter_test.sv]
// ----------------------------------------------------------------------------
// lock_table_arbiter_test
// drives lock requests into the arbiter: a directed pass over claims, grants, releases,
// pending and ignored requests and a full table, then random requests mostly
// on the keys held in the table, with random gaps on both channels
// ----------------------------------------------------------------------------
module lock_table_arbiter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic        FnAcquire      = 1'b0;
  localparam logic        FnRelease      = 1'b1;
  localparam int unsigned RandomRequests = 400;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned DrainCycles    = 40;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid;
  logic                            in_stall;
  logic                            func;
  logic [lta_pkg::OwnerWidth-1:0]  req_core;
  logic [lta_pkg::KeyWidthDef-1:0] lock_key;
  logic                            out_valid;
  logic                            out_stall;
  logic [lta_pkg::StatusWidth-1:0] status;
  logic                            clear_mailbox;
  logic [lta_pkg::SlotWidth-1:0]   entry_slot;
  int                              fail_count;
  int                              pending;
  int unsigned                     cycle_count;

  // per side: remaining requests of a stretch with no idling
  int unsigned                     calm_left [2];

  logic [lta_pkg::KeyWidthDef-1:0] lock_pool [lta_pkg::TableEntriesDef];
  logic [lta_pkg::OwnerWidth-1:0]  last_taker [lta_pkg::TableEntriesDef];

  lock_table_arbiter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .func_i            (func),
    .requesting_core_i (req_core),
    .lock_key_i        (lock_key),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (status),
    .clear_mailbox_o   (clear_mailbox),
    .entry_slot_o      (entry_slot)
  );

  lock_table_checker chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .func_i            (func),
    .requesting_core_i (req_core),
    .lock_key_i        (lock_key),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .status_i          (status),
    .clear_mailbox_i   (clear_mailbox),
    .entry_slot_i      (entry_slot),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned draw_gap(input int unsigned side);
    if (calm_left[side] != 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm_left[side] = $urandom_range(10, 40);
    return $urandom_range(0, 18);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue_request(input logic                            fn,
                               input logic [lta_pkg::OwnerWidth-1:0]  core,
                               input logic [lta_pkg::KeyWidthDef-1:0] key);
    int unsigned gap;
    gap = draw_gap(0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    func     <= fn;
    req_core <= core;
    lock_key <= key;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    @(negedge clk_i);
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = draw_gap(1);
      // stall is raised regardless of out_valid so it lands on every phase
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    logic                            fn;
    logic [lta_pkg::OwnerWidth-1:0]  core;
    logic [lta_pkg::KeyWidthDef-1:0] key;
    int unsigned                     pick;
    in_valid     = 1'b0;
    func         = FnAcquire;
    req_core     = '0;
    lock_key     = '0;
    rst_ni       = 1'b0;
    calm_left[0] = 0;
    calm_left[1] = 0;
    lock_pool[0] = 16'h0000;
    lock_pool[1] = 16'hFFFF;
    for (int i = 2; i < lta_pkg::TableEntriesDef; i++) begin
      lock_pool[i] = 16'((i - 1) * 16'h1111);
    end
    for (int i = 0; i < lta_pkg::TableEntriesDef; i++) last_taker[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // acquire claims slot 0, then owner repeat, other core, foreign release, owner release
    issue_request(FnAcquire, 2'd0, lock_pool[0]);
    issue_request(FnAcquire, 2'd0, lock_pool[0]);
    issue_request(FnAcquire, 2'd1, lock_pool[0]);
    issue_request(FnRelease, 2'd2, lock_pool[0]);
    issue_request(FnRelease, 2'd0, lock_pool[0]);
    // a release that misses still claims a slot
    issue_request(FnRelease, 2'd3, lock_pool[1]);
    issue_request(FnAcquire, 2'd3, lock_pool[1]);
    issue_request(FnRelease, 2'd3, lock_pool[1]);
    issue_request(FnRelease, 2'd1, lock_pool[0]);
    // fill the rest of the table, then both kinds on a full table
    for (int i = 2; i < lta_pkg::TableEntriesDef; i++) begin
      issue_request(FnAcquire, 2'(i), lock_pool[i]);
      last_taker[i] = 2'(i);
    end
    issue_request(FnAcquire, 2'd2, 16'h4321);
    issue_request(FnRelease, 2'd1, 16'h1234);

    for (int n = 0; n < RandomRequests; n++) begin
      pick = $urandom_range(0, lta_pkg::TableEntriesDef - 1);
      fn   = 1'($urandom_range(0, 1));
      core = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 6) == 0) begin
        key = 16'($urandom_range(0, 65535));
      end else begin
        key = lock_pool[pick];
        // releases lean towards the core that last asked for the lock
        if (fn == FnRelease && $urandom_range(0, 1) == 1) core = last_taker[pick];
        if (fn == FnAcquire) last_taker[pick] = core;
      end
      issue_request(fn, core, key);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/lta_pkg.sv
src/lta_ram.sv
src/lta_search.sv
src/lock_table_arbiter.sv
tb/lock_table_checker.sv
tb/lock_table_arbiter_test.sv
